// ===== design/sagq_pkg.sv =====
// ----------------------------------------------------------------------------
// sagq_pkg
// Shared constants, gear table and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sagq_pkg;

	localparam int ANGLE_W        = 13;
	localparam int COUNT_W        = 8;
	localparam int GEAR_W         = 5;
	localparam int REG_IDX_W      = 2;
	localparam int TABLE_DEPTH_DEF = 48;
	localparam int GEAR_TABLE_LEN = 48;
	localparam int GEAR_IDX_W     = 6;

	localparam logic [REG_IDX_W-1:0] REG_ANGLE_MIN    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ANGLE_MAX    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STABLE_NEEDED = 2'd2;

	localparam logic [ANGLE_W-1:0] ANGLE_MIN_RST  = 13'd1000;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST  = 13'd4000;
	localparam logic [COUNT_W-1:0] STABLE_RST     = 8'd10;
	localparam logic [ANGLE_W-1:0] ACCEPT_LOW     = 13'd1000;
	localparam logic [ANGLE_W-1:0] ACCEPT_HIGH    = 13'd4000;
	localparam logic [ANGLE_W-1:0] STEADY_BAND    = 13'd10;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 8'd255;

	localparam logic [GEAR_W-1:0] GEAR_TABLE [GEAR_TABLE_LEN] = '{
		5'd8,  5'd8,  5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,
		5'd9,  5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd11,
		5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12,
		5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13,
		5'd13, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd15,
		5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16
	};

	typedef struct packed {
		logic accept;
		logic div_step;
		logic load_out;
	} sagq_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_last;
	} sagq_status_t;

endpackage

// ===== design/sagq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sagq_ctrl
// Sequencer: accept, serial divide when a lookup is needed, hand result to the output register.
// ----------------------------------------------------------------------------
module sagq_ctrl
	import sagq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  sagq_status_t status,
	output sagq_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.div_step = 1'b0;
		cmd.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = status.need_div ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				cmd.load_out = !out_valid_q || !out_stall;
				if (cmd.load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/sagq_datapath.sv =====
// ----------------------------------------------------------------------------
// sagq_datapath
// Config registers, stability counter, restoring divider, gear lookup.
// ----------------------------------------------------------------------------
module sagq_datapath
	import sagq_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] write_index,
	input  logic [ANGLE_W-1:0]   write_data,
	input  logic [ANGLE_W-1:0]   angle_sample,
	input  sagq_cmd_t            cmd,
	output sagq_status_t         status,
	output logic [GEAR_W-1:0]    gear_value,
	output logic                 gear_updated
);

	localparam int MW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NW = ANGLE_W + MW;
	localparam int SW = $clog2(NW);

	logic [ANGLE_W-1:0] angle_min_q;
	logic [ANGLE_W-1:0] angle_max_q;
	logic [COUNT_W-1:0] stable_needed_q;
	logic [ANGLE_W-1:0] last_angle_q;
	logic [COUNT_W-1:0] count_q;
	logic [GEAR_W-1:0]  cur_gear_q;
	logic               upd_q;
	logic               neg_q;
	logic [ANGLE_W-1:0] den_q;
	logic [ANGLE_W-1:0] rem_q;
	logic [NW-1:0]      quo_q;
	logic [SW-1:0]      step_q;
	logic [GEAR_W-1:0]  gear_value_q;
	logic               gear_updated_q;

	logic [ANGLE_W-1:0] a_c;
	logic [ANGLE_W-1:0] dist_c;
	logic [COUNT_W-1:0] cnt_step_c;
	logic               trig_c;
	logic [ANGLE_W:0]   diff_c;
	logic [ANGLE_W:0]   diff_abs_c;
	logic [ANGLE_W:0]   span_c;
	logic [ANGLE_W:0]   span_abs_c;
	logic [NW-1:0]      prod_c;
	logic [ANGLE_W:0]   shift_c;
	logic               ge_c;
	logic [ANGLE_W:0]   rem_sub_c;
	logic [NW-1:0]      idx_c;
	logic [GEAR_IDX_W-1:0] tbl_idx_c;
	logic [GEAR_W-1:0]  gear_c;

	always_comb begin
		a_c = (angle_sample > ACCEPT_LOW && angle_sample < ACCEPT_HIGH) ?
			angle_sample : last_angle_q;
		dist_c = (a_c >= last_angle_q) ? (a_c - last_angle_q) : (last_angle_q - a_c);
		if (dist_c < STEADY_BAND) begin
			cnt_step_c = (count_q == COUNT_MAX) ? count_q : count_q + 8'd1;
		end else begin
			cnt_step_c = (count_q == '0) ? count_q : count_q - 8'd1;
		end
		trig_c     = cnt_step_c >= stable_needed_q;
		diff_c     = {1'b0, a_c} - {1'b0, angle_min_q};
		diff_abs_c = diff_c[ANGLE_W] ? ((ANGLE_W+1)'(0) - diff_c) : diff_c;
		span_c     = {1'b0, angle_max_q} - {1'b0, angle_min_q};
		span_abs_c = span_c[ANGLE_W] ? ((ANGLE_W+1)'(0) - span_c) : span_c;
		prod_c     = NW'(diff_abs_c[ANGLE_W-1:0]) * NW'(TABLE_DEPTH - 1);
		status.need_div = trig_c && (angle_max_q != angle_min_q);
		status.div_last = step_q == SW'(NW - 1);
	end

	always_comb begin
		shift_c   = {rem_q, quo_q[NW-1]};
		ge_c      = shift_c >= {1'b0, den_q};
		rem_sub_c = ge_c ? (shift_c - {1'b0, den_q}) : shift_c;
	end

	always_comb begin
		if (neg_q && quo_q != '0) begin
			idx_c = NW'(1);
		end else if (quo_q > NW'(TABLE_DEPTH - 1)) begin
			idx_c = NW'(TABLE_DEPTH - 2);
		end else begin
			idx_c = quo_q;
		end
		if (idx_c > NW'(GEAR_TABLE_LEN - 1)) begin
			tbl_idx_c = GEAR_IDX_W'(GEAR_TABLE_LEN - 1);
		end else begin
			tbl_idx_c = idx_c[GEAR_IDX_W-1:0];
		end
		gear_c = upd_q ? GEAR_TABLE[tbl_idx_c] : cur_gear_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_min_q     <= ANGLE_MIN_RST;
			angle_max_q     <= ANGLE_MAX_RST;
			stable_needed_q <= STABLE_RST;
			last_angle_q    <= '0;
			count_q         <= '0;
			cur_gear_q      <= '0;
			upd_q           <= 1'b0;
		end else begin
			if (write_en) begin
				case (write_index)
					REG_ANGLE_MIN:     angle_min_q     <= write_data;
					REG_ANGLE_MAX:     angle_max_q     <= write_data;
					REG_STABLE_NEEDED: stable_needed_q <= write_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept) begin
				last_angle_q <= a_c;
				count_q      <= trig_c ? (stable_needed_q >> 1) : cnt_step_c;
				upd_q        <= status.need_div;
			end
			if (cmd.load_out) begin
				cur_gear_q <= gear_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			neg_q  <= diff_c[ANGLE_W] ^ span_c[ANGLE_W];
			den_q  <= span_abs_c[ANGLE_W-1:0];
			rem_q  <= '0;
			quo_q  <= prod_c;
			step_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= rem_sub_c[ANGLE_W-1:0];
			quo_q  <= {quo_q[NW-2:0], ge_c};
			step_q <= step_q + SW'(1);
		end
		if (cmd.load_out) begin
			gear_value_q   <= gear_c;
			gear_updated_q <= upd_q;
		end
	end

	assign gear_value   = gear_value_q;
	assign gear_updated = gear_updated_q;

endmodule

// ===== design/stable_angle_gear_quantizer.sv =====
// ----------------------------------------------------------------------------
// stable_angle_gear_quantizer
// Lever angle stability filter and linear map to a gear table entry.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  in       | in_valid/in_stall  | angle_sample
//  out      | out_valid/out_stall| gear_value, gear_updated
//  config   | write_en           | write_index, write_data
//
//  A sample that causes no lookup goes from accept straight to the done
//  state, which loads the output register; one with a lookup first passes
//  through the serial restoring divider, one quotient bit per cycle
//  (13 + clog2(TABLE_DEPTH) bits, 19 at 48 entries).
//  in_stall stays high from accept until the result moves to the output
//  register, which waits there while out_stall is high. No clearing pass
//  after reset.
// ----------------------------------------------------------------------------
module stable_angle_gear_quantizer
	import sagq_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 write_en,
	input  logic [REG_IDX_W-1:0] write_index,
	input  logic [ANGLE_W-1:0]   write_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ANGLE_W-1:0]   angle_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [GEAR_W-1:0]    gear_value,
	output logic                 gear_updated
);

	sagq_cmd_t    cmd;
	sagq_status_t status;

	sagq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sagq_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_en     (write_en),
		.write_index  (write_index),
		.write_data   (write_data),
		.angle_sample (angle_sample),
		.cmd          (cmd),
		.status       (status),
		.gear_value   (gear_value),
		.gear_updated (gear_updated)
	);

endmodule

// ===== design/sagq_checker.sv =====
// ----------------------------------------------------------------------------
// sagq_checker
// Port-level checks on the quantizer, attached by bind.
// ----------------------------------------------------------------------------
module sagq_checker
	import sagq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [GEAR_W-1:0]    gear_value,
	input logic                 gear_updated
);

	// one transaction in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while previous transaction in flight");

	// a new result only follows a cycle with input blocked
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a transaction in progress");

	a_gear_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && gear_updated |-> gear_value >= 5'd8 && gear_value <= 5'd16)
		else $error("looked-up gear outside table values");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gear_value) && $stable(gear_updated))
		else $error("stalled result changed");

endmodule

bind stable_angle_gear_quantizer sagq_checker u_sagq_checker (.*);
